### hdl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants, codes and control/status types of the seek table block.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int WORD_W      = 64;
	localparam int ROW_W       = 4 * WORD_W;

	localparam int ACT_W       = 2;
	localparam int STATUS_W    = 4;
	localparam int OUT_IDX_W   = 10;
	localparam int OUT_TOT_W   = 11;
	localparam int LIMIT_W     = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 5 * WORD_W;
	localparam int OUT_FIELD_W = STATUS_W + OUT_IDX_W + OUT_TOT_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	// actions
	localparam logic [ACT_W-1:0] ACT_CLEAR       = 2'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND      = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP_COMP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_LOOKUP_DEC  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HDR_END     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO          = 4'd1;
	localparam logic [STATUS_W-1:0] ST_HEADER        = 4'd2;
	localparam logic [STATUS_W-1:0] ST_COMP_OVF      = 4'd3;
	localparam logic [STATUS_W-1:0] ST_PAST_FILE     = 4'd4;
	localparam logic [STATUS_W-1:0] ST_DECOMP_OVF    = 4'd5;
	localparam logic [STATUS_W-1:0] ST_GAP           = 4'd6;
	localparam logic [STATUS_W-1:0] ST_BACKWARDS     = 4'd7;
	localparam logic [STATUS_W-1:0] ST_FIRST_NONZERO = 4'd8;
	localparam logic [STATUS_W-1:0] ST_FULL          = 4'd9;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND     = 4'd10;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the input transaction
		logic dispatch;  // clear / full / scan set-up
		logic calc;      // form chunk ends
		logic check;     // validate and commit an append
		logic scan;      // one lookup step
		logic load_out;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             full;
		logic             hit;
		logic             scan_done;
	} stat_t;

endpackage

### hdl/cst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer of the seek table: one transaction at a time, output register.
// ----------------------------------------------------------------------------
module cst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  cst_pkg::stat_t stat,
	output cst_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_CALC     = 3'd2;
	localparam logic [2:0] S_CHECK    = 3'd3;
	localparam logic [2:0] S_SCAN     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.dispatch = 1'b1;
				priority if (stat.action == cst_pkg::ACT_CLEAR)
					state_d = S_DONE;
				else if (stat.action == cst_pkg::ACT_APPEND)
					state_d = stat.full ? S_DONE : S_CALC;
				else
					state_d = S_SCAN;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit || stat.scan_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/cst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp
// Seek table datapath: config registers, entry memory, checks, lookup scan.
// ----------------------------------------------------------------------------
module cst_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cst_pkg::cmd_t                     cmd,
	output cst_pkg::stat_t                    stat,
	input  logic                              cfg_we,
	input  logic [cst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cst_pkg::WORD_W-1:0]        cfg_data,
	input  logic [cst_pkg::ACT_W-1:0]         s_tuser,
	input  logic [cst_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic [cst_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int W = cst_pkg::WORD_W;

	// configuration
	logic [W-1:0]                   hdr_end_q;
	logic [W-1:0]                   file_len_q;
	logic [cst_pkg::LIMIT_W-1:0]    entry_limit_q;

	// captured transaction
	logic [cst_pkg::ACT_W-1:0]      act_q;
	logic [W-1:0]                   coff_q, csize_q, doff_q, dsize_q, query_q;

	// table state
	logic [cst_pkg::CNT_W-1:0]      count_q;
	logic [W-1:0]                   last_cend_q, last_dend_q;
	logic [cst_pkg::ROW_W-1:0]      row_mem [cst_pkg::MAX_ENTRIES];

	// append pipeline
	logic [W:0]                     cend_s1, dend_s1;
	logic [cst_pkg::STATUS_W-1:0]   chk_status;

	// scan
	logic [cst_pkg::CNT_W-1:0]      scan_addr_q;
	logic                           rd_valid_q;
	logic [cst_pkg::IDX_W-1:0]      rd_tag_q;
	logic [cst_pkg::ROW_W-1:0]      row_q;
	logic                           issue;
	logic [W-1:0]                   sel_off, sel_end;
	logic                           match;
	logic                           full;

	// result and output
	logic [cst_pkg::STATUS_W-1:0]   res_status_q, out_status_q;
	logic [cst_pkg::CNT_W-1:0]      res_idx_q, res_total_q;
	logic [cst_pkg::OUT_IDX_W-1:0]  out_idx_q;
	logic [cst_pkg::OUT_TOT_W-1:0]  out_total_q;

	assign full = (32'(count_q) >= 32'(entry_limit_q)) ||
	              (32'(count_q) >= 32'(cst_pkg::MAX_ENTRIES));

	// row layout, low to high: comp offset, comp end, decomp offset, decomp end
	always_comb begin
		if (act_q == cst_pkg::ACT_LOOKUP_COMP) begin
			sel_off = row_q[W-1:0];
			sel_end = row_q[2*W-1:W];
		end else begin
			sel_off = row_q[3*W-1:2*W];
			sel_end = row_q[4*W-1:3*W];
		end
	end

	assign issue = (scan_addr_q < count_q);
	assign match = rd_valid_q && (sel_off <= query_q) && (query_q < sel_end);

	assign stat.action    = act_q;
	assign stat.full      = full;
	assign stat.hit       = match;
	assign stat.scan_done = !issue && !rd_valid_q;

	// fixed-order entry validation
	always_comb begin
		priority if (csize_q == '0 || dsize_q == '0)
			chk_status = cst_pkg::ST_ZERO;
		else if (coff_q < hdr_end_q)
			chk_status = cst_pkg::ST_HEADER;
		else if (cend_s1[W])
			chk_status = cst_pkg::ST_COMP_OVF;
		else if (cend_s1[W-1:0] > file_len_q)
			chk_status = cst_pkg::ST_PAST_FILE;
		else if (dend_s1[W])
			chk_status = cst_pkg::ST_DECOMP_OVF;
		else if (count_q != '0 && last_dend_q != doff_q)
			chk_status = cst_pkg::ST_GAP;
		else if (count_q != '0 && last_cend_q > coff_q)
			chk_status = cst_pkg::ST_BACKWARDS;
		else if (count_q == '0 && doff_q != '0)
			chk_status = cst_pkg::ST_FIRST_NONZERO;
		else
			chk_status = cst_pkg::ST_OK;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_end_q     <= '0;
			file_len_q    <= '1;
			entry_limit_q <= cst_pkg::LIMIT_RESET;
			count_q       <= '0;
			scan_addr_q   <= '0;
			rd_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cst_pkg::CFG_HDR_END:     hdr_end_q     <= cfg_data;
					cst_pkg::CFG_FILE_LEN:    file_len_q    <= cfg_data;
					cst_pkg::CFG_ENTRY_LIMIT: entry_limit_q <= cfg_data[cst_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.dispatch && act_q == cst_pkg::ACT_CLEAR)
				count_q <= '0;
			if (cmd.check && chk_status == cst_pkg::ST_OK)
				count_q <= count_q + 1'b1;
			if (cmd.dispatch) begin
				scan_addr_q <= '0;
				rd_valid_q  <= 1'b0;
			end else if (cmd.scan) begin
				rd_valid_q <= issue;
				if (issue)
					scan_addr_q <= scan_addr_q + 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= s_tuser;
			coff_q  <= s_tdata[W-1:0];
			csize_q <= s_tdata[2*W-1:W];
			doff_q  <= s_tdata[3*W-1:2*W];
			dsize_q <= s_tdata[4*W-1:3*W];
			query_q <= s_tdata[5*W-1:4*W];
		end
		if (cmd.calc) begin
			cend_s1 <= {1'b0, coff_q} + {1'b0, csize_q};
			dend_s1 <= {1'b0, doff_q} + {1'b0, dsize_q};
		end
		if (cmd.scan)
			rd_tag_q <= scan_addr_q[cst_pkg::IDX_W-1:0];
		if (cmd.check && chk_status == cst_pkg::ST_OK) begin
			last_cend_q <= cend_s1[W-1:0];
			last_dend_q <= dend_s1[W-1:0];
		end

		// result staging
		if (cmd.dispatch) begin
			if (act_q == cst_pkg::ACT_CLEAR) begin
				res_status_q <= cst_pkg::ST_OK;
				res_idx_q    <= '0;
				res_total_q  <= '0;
			end else if (act_q == cst_pkg::ACT_APPEND) begin
				res_status_q <= cst_pkg::ST_FULL;
				res_idx_q    <= '0;
				res_total_q  <= count_q;
			end
		end
		if (cmd.check) begin
			res_status_q <= chk_status;
			if (chk_status == cst_pkg::ST_OK) begin
				res_idx_q   <= count_q;
				res_total_q <= count_q + 1'b1;
			end else begin
				res_idx_q   <= '0;
				res_total_q <= count_q;
			end
		end
		if (cmd.scan) begin
			if (match) begin
				res_status_q <= cst_pkg::ST_OK;
				res_idx_q    <= cst_pkg::CNT_W'(rd_tag_q);
				res_total_q  <= count_q;
			end else if (!issue && !rd_valid_q) begin
				res_status_q <= cst_pkg::ST_NOT_FOUND;
				res_idx_q    <= '0;
				res_total_q  <= count_q;
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_idx_q    <= cst_pkg::OUT_IDX_W'(res_idx_q);
			out_total_q  <= cst_pkg::OUT_TOT_W'(res_total_q);
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.check && chk_status == cst_pkg::ST_OK)
			row_mem[count_q[cst_pkg::IDX_W-1:0]] <=
				{dend_s1[W-1:0], doff_q, cend_s1[W-1:0], coff_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && issue)
			row_q <= row_mem[scan_addr_q[cst_pkg::IDX_W-1:0]];
	end

	assign m_tdata = {{(cst_pkg::OUT_DATA_W - cst_pkg::OUT_FIELD_W){1'b0}},
	                  out_total_q, out_idx_q, out_status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(cst_pkg::MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_commit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && chk_status == cst_pkg::ST_OK) |=> count_q == $past(count_q) + 1'b1)
		else $error("append commit did not advance count by one");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dispatch && act_q == cst_pkg::ACT_CLEAR) |=> count_q == '0)
		else $error("clear left entries in the table");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && match) |-> (cst_pkg::CNT_W'(rd_tag_q) < count_q))
		else $error("lookup hit on an entry beyond the count");

endmodule

### hdl/chunk_seek_table_validate_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_seek_table_validate_lookup
// Seek table of compressed chunks with append validation and offset lookup.
// ----------------------------------------------------------------------------
// Usage
//  - Input stream (s_*): one transaction per request. s_tuser carries the
//    action (clear, append, lookup compressed, lookup decompressed); s_tdata
//    carries the entry fields and the query offset.
//  - Output stream (m_*): exactly one result transaction per request:
//    status, entry index and entry total.
//  - cfg_we/cfg_index/cfg_data write the header end, file length and entry
//    limit registers; write only while no request is in flight.
//  - From acceptance to m_tvalid a clear and a refused (full) append pass
//    the dispatch and done states, an append dispatch, calc, check and
//    done, a lookup dispatch, scan and done. The scan runs over the entries
//    until a hit (all stored entries when nothing matches), reading one
//    memory row per cycle through the single read port of the entry memory.
//  - One request at a time; s_tready is high only between requests, so the
//    next request is taken at the earliest in the cycle after a result is
//    loaded. A result waiting in the output register does not block
//    acceptance of the next request; finishing it waits until the register
//    is free.
//  - Reset: the table is empty, header end 0, file length all ones,
//    entry limit 1024. The entry memory itself is not cleared; only entries
//    below the count are ever read.
//  - A stalled receiver holds m_tvalid/m_tdata stable until m_tready.
// ----------------------------------------------------------------------------
module chunk_seek_table_validate_lookup (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [cst_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cst_pkg::WORD_W-1:0]       cfg_data,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata, low bit up: comp_offset, comp_size, decomp_offset,
	// decomp_size, query_offset (64 bits each)
	input  logic [cst_pkg::IN_DATA_W-1:0]    s_tdata,
	// tuser: action (2 bits)
	input  logic [cst_pkg::ACT_W-1:0]        s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata, low bit up: status (4), entry_index (10), entry_total (11),
	// zero padding
	output logic [cst_pkg::OUT_DATA_W-1:0]   m_tdata
);

	cst_pkg::cmd_t  cmd;   // sequencer commands
	cst_pkg::stat_t stat;  // datapath status back to the sequencer

	cst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata)
	);

endmodule
